// ===== sv/sirs_pkg.sv =====
package sirs_pkg;

  localparam int VALUE_W         = 32;
  localparam int BASE_LEN_W      = 7;
  localparam int INDEX_W         = 6;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_DEPTH     = 32;
  localparam int DEF_MAX_SYMBOLS = 64;

  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] SYM_NUL   = 8'h00;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERROR,
    ST_CHECK_RD,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_t;

endpackage

// ===== sv/sirs_symtab.sv =====
module sirs_symtab #(
  parameter int DEPTH = sirs_pkg::DEF_MAX_SYMBOLS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [sirs_pkg::CHAR_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [sirs_pkg::CHAR_W-1:0] rd_data
);
  import sirs_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sirs_divider.sv =====
module sirs_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sirs_pkg::VALUE_W-1:0]    dividend,
  input  logic [sirs_pkg::BASE_LEN_W-1:0] divisor,
  output logic                            done,
  output logic [sirs_pkg::VALUE_W-1:0]    quotient,
  output logic [sirs_pkg::BASE_LEN_W-1:0] remainder
);
  import sirs_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic                  active;
  logic [CNT_W-1:0]      cnt;
  logic [BASE_LEN_W:0]   trial;
  logic                  fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {remainder, quotient[VALUE_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (active) begin
      quotient  <= {quotient[VALUE_W-2:0], fits};
      remainder <= fits ? BASE_LEN_W'(trial - {1'b0, divisor}) : BASE_LEN_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      cnt    <= '0;
      done   <= 1'b0;
    end else if (active) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(VALUE_W - 1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ===== sv/signed_integer_to_radix_symbols.sv =====
// Write-symbol item: stored at the transfer edge, no result, next item in the next cycle.
// Convert item, L = base_length, D = digits: each of the L symbols is read, then checked;
//   the D digits run one by one through the shared 32-step divider, a minus sign follows
//   if negative, and each digit is read, then emitted. A base_length out of range errors.
// Throughput: one item at a time; busy drops as the last result is registered, and the
// receiver cannot stall. Reset (rst, synchronous) clears base_length to 0 and goes idle.
module signed_integer_to_radix_symbols #(
  parameter int MAX_SYMBOLS = sirs_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [sirs_pkg::INDEX_W-1:0]      symbol_index,
  input  logic [sirs_pkg::CHAR_W-1:0]       symbol_byte,
  input  logic signed [sirs_pkg::VALUE_W-1:0] value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sirs_pkg::BASE_LEN_W-1:0]   cfg_data,
  output logic                              result_strobe,
  output logic [sirs_pkg::CHAR_W-1:0]       char_byte,
  output logic                              status,
  output logic                              last
);
  import sirs_pkg::*;

  localparam int AW    = $clog2(MAX_SYMBOLS);
  localparam int DW    = AW;
  localparam int PTR_W = $clog2(DIGIT_DEPTH);

  state_t state, state_next;

  // configuration and item registers
  logic [BASE_LEN_W-1:0] base_length;
  logic [BASE_LEN_W-1:0] radix;
  logic [VALUE_W-1:0]    mag;
  logic                  neg;

  // symbol check
  logic [AW-1:0]         vidx;
  logic [(1<<CHAR_W)-1:0] seen;
  logic                  sym_bad;
  logic                  sym_last;
  logic                  len_bad;

  // digit stack, least significant digit first
  logic [DW-1:0]         stack [DIGIT_DEPTH];
  logic [PTR_W:0]        nd;
  logic [PTR_W-1:0]      ptr;
  logic                  digits_done;

  // symbol table port
  logic                  tab_wr_en;
  logic                  tab_rd_en;
  logic [AW-1:0]         tab_rd_addr;
  logic [CHAR_W-1:0]     tab_rd_data;

  // divider port
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_W-1:0]    div_quo;
  logic [BASE_LEN_W-1:0] div_rem;

  // result register inputs
  logic                  strobe_next;
  logic [CHAR_W-1:0]     char_next;
  logic                  status_next;
  logic                  last_next;

  logic                  accept;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign tab_wr_en = accept && (cmd == CMD_WRITE) && (32'(symbol_index) < MAX_SYMBOLS);

  assign len_bad     = (base_length < BASE_LEN_W'(2)) || (32'(base_length) > MAX_SYMBOLS);
  assign sym_bad     = (tab_rd_data == SYM_NUL) || (tab_rd_data == SYM_PLUS) ||
                       (tab_rd_data == SYM_MINUS) || seen[tab_rd_data];
  assign sym_last    = (9'(vidx) == 9'(radix) - 9'd1);
  assign digits_done = (div_quo == '0) || (nd == (PTR_W+1)'(DIGIT_DEPTH - 1));

  sirs_symtab #(
    .DEPTH (MAX_SYMBOLS),
    .AW    (AW)
  ) u_symtab (
    .clk     (clk),
    .wr_en   (tab_wr_en),
    .wr_addr (AW'(symbol_index)),
    .wr_data (symbol_byte),
    .rd_en   (tab_rd_en),
    .rd_addr (tab_rd_addr),
    .rd_data (tab_rd_data)
  );

  sirs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd == CMD_CONVERT)) begin
          state_next = len_bad ? ST_ERROR : ST_CHECK_RD;
        end
      end
      ST_ERROR:    state_next = ST_IDLE;
      ST_CHECK_RD: state_next = ST_CHECK;
      ST_CHECK: begin
        if (sym_bad) begin
          state_next = ST_ERROR;
        end else if (sym_last) begin
          state_next = ST_DIV_GO;
        end else begin
          state_next = ST_CHECK_RD;
        end
      end
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (!digits_done) begin
            state_next = ST_DIV_GO;
          end else if (neg) begin
            state_next = ST_SIGN;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_SIGN:     state_next = ST_OUT_RD;
      ST_OUT_RD:   state_next = ST_OUT_EMIT;
      ST_OUT_EMIT: state_next = (ptr == '0) ? ST_IDLE : ST_OUT_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy        = 1'b1;
    tab_rd_en   = 1'b0;
    tab_rd_addr = vidx;
    div_start   = 1'b0;
    strobe_next = 1'b0;
    char_next   = SYM_NUL;
    status_next = STATUS_OK;
    last_next   = 1'b0;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_ERROR: begin
        strobe_next = 1'b1;
        status_next = STATUS_BAD;
        last_next   = 1'b1;
      end
      ST_CHECK_RD: tab_rd_en = 1'b1;
      ST_DIV_GO:   div_start = 1'b1;
      ST_SIGN: begin
        strobe_next = 1'b1;
        char_next   = SYM_MINUS;
      end
      ST_OUT_RD: begin
        tab_rd_en   = 1'b1;
        tab_rd_addr = AW'(stack[ptr]);
      end
      ST_OUT_EMIT: begin
        strobe_next = 1'b1;
        char_next   = tab_rd_data;
        last_next   = (ptr == '0);
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      base_length   <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= strobe_next;
      if (cfg_valid && cfg_ready) begin
        base_length <= cfg_data;
      end
    end
  end

  // result registers hold for exactly one cycle of strobe
  always_ff @(posedge clk) begin
    char_byte <= char_next;
    status    <= status_next;
    last      <= last_next;
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && (cmd == CMD_CONVERT)) begin
          radix <= base_length;
          neg   <= value[VALUE_W-1];
          // the most negative value wraps to its exact magnitude
          mag   <= value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
          vidx  <= '0;
          nd    <= '0;
          seen  <= '0;
        end
      end
      ST_CHECK: begin
        seen[tab_rd_data] <= 1'b1;
        vidx              <= vidx + 1'b1;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          stack[nd[PTR_W-1:0]] <= DW'(div_rem);
          mag                  <= div_quo;
          nd                   <= nd + 1'b1;
          ptr                  <= nd[PTR_W-1:0];
        end
      end
      ST_OUT_EMIT: begin
        if (ptr != '0) begin
          ptr <= ptr - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
